FILE: sv/aes_pkg.sv
// AES-128 shared constants, types and byte-level functions.
package aes_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int RK_DEPTH   = 22;
  localparam int RK_AW      = 5;
  localparam int RND_W      = 4;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef logic [127:0] blk_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;     // take input block, add initial round key (key 0 encrypt, key 10 decrypt)
    logic             round;    // one cipher round
    logic             last;     // final round (no mix columns)
    logic             op;       // OP_ENC / OP_DEC
    logic [RND_W-1:0] rnd;      // round key index to apply
  } dp_cmd_t;

  // key schedule -> controller
  typedef struct packed {
    logic             start;
    logic             busy;
  } ks_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [NUM_ROUNDS] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of a 128-bit block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input blk_t b, input int i);
    get_byte = b[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [3:0] a, input logic [7:0] b);
    logic [7:0] res;
    logic [7:0] t;
    res = 8'h00;
    t = b;
    for (int i = 0; i < 4; i++) begin
      if (a[i]) res = res ^ t;
      t = xtime(t);
    end
    gmul = res;
  endfunction

endpackage

FILE: sv/aes_key_sched.sv
// AES-128 key expansion: one round key per cycle into a 22-word store.
module aes_key_sched (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [63:0]           cfg_data,
  input  logic [aes_pkg::RND_W-1:0] rd_rnd,
  output aes_pkg::blk_t         rd_key,
  output aes_pkg::ks_stat_t     ks_stat
);
  import aes_pkg::*;

  logic [63:0]      key_high_r, key_high_nxt;
  logic [63:0]      key_low_r, key_low_nxt;
  blk_t             prev_r;
  logic [RND_W-1:0] cnt_r;
  logic             busy_r;
  logic             start_r;
  logic [63:0]      mem_hi [NUM_ROUNDS+1];
  logic [63:0]      mem_lo [NUM_ROUNDS+1];
  blk_t             next_key;
  blk_t             wr_key;
  logic [31:0]      w [4];
  logic [31:0]      t;
  logic [31:0]      pw;

  always_comb begin
    key_high_nxt = key_high_r;
    key_low_nxt  = key_low_r;
    if (cfg_we && cfg_addr == CFG_KEY_HIGH) key_high_nxt = cfg_data;
    if (cfg_we && cfg_addr == CFG_KEY_LOW)  key_low_nxt  = cfg_data;
  end

  // next round key: word 0 from last word of previous key, words 1-3 chained
  always_comb begin
    pw = prev_r[31:0];
    t = {SBOX[pw[23:16]] ^ RCON[cnt_r - 4'd1], SBOX[pw[15:8]], SBOX[pw[7:0]],
         SBOX[pw[31:24]]};
    w[0] = prev_r[127:96] ^ t;
    w[1] = prev_r[95:64] ^ w[0];
    w[2] = prev_r[63:32] ^ w[1];
    w[3] = prev_r[31:0] ^ w[2];
    next_key = {w[0], w[1], w[2], w[3]};
    wr_key = (cnt_r == '0) ? prev_r : next_key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      busy_r     <= 1'b0;
      start_r    <= 1'b0;
      cnt_r      <= '0;
    end else begin
      key_high_r <= key_high_nxt;
      key_low_r  <= key_low_nxt;
      start_r    <= cfg_we;
      if (start_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == RND_W'(NUM_ROUNDS)) busy_r <= 1'b0;
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      prev_r <= {key_high_r, key_low_r};
    end else if (busy_r) begin
      prev_r <= wr_key;
      mem_hi[cnt_r] <= wr_key[127:64];
      mem_lo[cnt_r] <= wr_key[63:0];
    end
  end

  assign rd_key = {mem_hi[rd_rnd], mem_lo[rd_rnd]};
  assign ks_stat.start = start_r;
  assign ks_stat.busy  = busy_r;

endmodule

FILE: sv/aes_datapath.sv
// AES-128 round datapath: state register, one full round per cycle.
module aes_datapath (
  input  logic              clk,
  input  aes_pkg::dp_cmd_t  cmd,
  input  aes_pkg::blk_t     in_blk,
  input  aes_pkg::blk_t     rkey,
  output aes_pkg::blk_t     state
);
  import aes_pkg::*;

  blk_t       st_r;
  blk_t       st_nxt;
  logic [7:0] s  [16];
  logic [7:0] e  [16];
  logic [7:0] m  [16];
  logic [7:0] d  [16];
  logic [7:0] ak [16];
  logic [7:0] dm [16];
  blk_t       enc_o;
  blk_t       dec_o;

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = get_byte(st_r, i);
    // encrypt: sub, shift, mix (not last), add key
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        e[c*4+r] = SBOX[s[((c + r) % 4)*4 + r]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        m[c*4+r] = gmul(4'h2, e[c*4+r]) ^ gmul(4'h3, e[c*4+(r+1)%4])
                 ^ e[c*4+(r+2)%4] ^ e[c*4+(r+3)%4];
    for (int i = 0; i < 16; i++)
      enc_o[127-8*i -: 8] = (cmd.last ? e[i] : m[i]) ^ get_byte(rkey, i);
    // decrypt: inv shift, inv sub, add key, inv mix (not last)
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        d[c*4+r] = INV_SBOX[s[((c - r + 4) % 4)*4 + r]];
    for (int i = 0; i < 16; i++) ak[i] = d[i] ^ get_byte(rkey, i);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        dm[c*4+r] = gmul(4'he, ak[c*4+r]) ^ gmul(4'hb, ak[c*4+(r+1)%4])
                  ^ gmul(4'hd, ak[c*4+(r+2)%4]) ^ gmul(4'h9, ak[c*4+(r+3)%4]);
    for (int i = 0; i < 16; i++)
      dec_o[127-8*i -: 8] = cmd.last ? ak[i] : dm[i];

    st_nxt = st_r;
    if (cmd.load) st_nxt = in_blk ^ rkey;
    else if (cmd.round) st_nxt = (cmd.op == OP_DEC) ? dec_o : enc_o;
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign state = st_r;

endmodule

FILE: sv/aes_ctrl.sv
// AES-128 controller: handshakes, round counter, output register.
module aes_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  logic                  in_op,
  input  aes_pkg::ks_stat_t     ks_stat,
  input  logic                  out_tready,
  input  aes_pkg::blk_t         state,
  output logic                  in_tready,
  output logic                  out_tvalid,
  output aes_pkg::blk_t         out_blk,
  output aes_pkg::dp_cmd_t      cmd
);
  import aes_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [RND_W-1:0] cnt_r;
  logic             op_r;
  logic             ov_r;
  blk_t             ob_r;

  always_comb begin
    cmd.load  = in_fire;
    cmd.round = (st_r == ST_RUN);
    cmd.op    = in_fire ? in_op : op_r;
    cmd.last  = (cnt_r == RND_W'(NUM_ROUNDS));
    if (cmd.op == OP_DEC) cmd.rnd = in_fire ? RND_W'(NUM_ROUNDS) : RND_W'(NUM_ROUNDS) - cnt_r;
    else                  cmd.rnd = in_fire ? '0 : cnt_r;
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_fire) st_nxt = ST_RUN;
      ST_RUN:  if (cmd.last) st_nxt = ST_DONE;
      ST_DONE: if (!ov_r || out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign in_tready  = (st_r == ST_IDLE) && !ks_stat.busy && !ks_stat.start;
  assign out_tvalid = ov_r;
  assign out_blk    = ob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (in_fire) cnt_r <= RND_W'(1);
      else if (st_r == ST_RUN) cnt_r <= cnt_r + 4'd1;
      if (st_r == ST_DONE && (!ov_r || out_tready)) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) op_r <= in_op;
    if (st_r == ST_DONE && (!ov_r || out_tready)) ob_r <= state;
  end

endmodule

FILE: sv/aes128_block_cipher.sv
// AES-128 encrypt/decrypt top level.
// Channel | Dir | Contents
// in_     | in  | tdata[127:0] {block_low,block_high} (low bits block_high), tuser op
// out_    | out | tdata[127:0] {result_low,result_high} (low bits result_high)
// cfg_    | in  | we, addr 0 key_high / 1 key_low, data 64b
// Each block is loaded, passes ten rounds through the single round unit,
// then goes to the output register. The result register lets the next
// block start while a result waits, unless it is still full.
// A key write expands all round keys into the store; input is held off meanwhile.
// Reset is synchronous, active low; round keys need a key write before use.
module aes128_block_cipher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // block_high[63:0], block_low[127:64]
  input  logic         in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // result_high[63:0], result_low[127:64]
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [63:0]  cfg_data
);
  import aes_pkg::*;

  dp_cmd_t   cmd;
  ks_stat_t  ks_stat;
  blk_t      rkey;
  blk_t      state;
  blk_t      out_blk;
  logic      in_fire;

  assign in_fire = in_tvalid && in_tready;

  aes_key_sched u_ks (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_data,
    .rd_rnd(cmd.rnd), .rd_key(rkey), .ks_stat
  );

  aes_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_op(in_tuser), .ks_stat, .out_tready,
    .state, .in_tready, .out_tvalid, .out_blk, .cmd
  );

  aes_datapath u_dp (
    .clk, .cmd, .in_blk({in_tdata[63:0], in_tdata[127:64]}), .rkey, .state
  );

  assign out_tdata = {out_blk[63:0], out_blk[127:64]};

endmodule
